// ===== design/rle_byte_stream_decoder_top_defines.svh =====
// Assertion macros for the run-length byte stream decoder.
`ifndef RLE_BYTE_STREAM_DECODER_TOP_DEFINES_SVH
`define RLE_BYTE_STREAM_DECODER_TOP_DEFINES_SVH

`ifndef SYNTH
`define RBSD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define RBSD_ASSERT(name, prop, msg)
`endif

`ifndef SYNTH
`define RBSD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBSD_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== design/rbsd_pkg.sv =====
// Types and constants of the run-length byte stream decoder.
`default_nettype none

package rbsd_pkg;

    // Parser phases
    localparam logic [2:0] PH_LEN_LO   = 3'd0;
    localparam logic [2:0] PH_LEN_HI   = 3'd1;
    localparam logic [2:0] PH_CTRL     = 3'd2;
    localparam logic [2:0] PH_COUNT_LO = 3'd3;
    localparam logic [2:0] PH_RUN_DATA = 3'd4;
    localparam logic [2:0] PH_HELD     = 3'd5;
    localparam logic [2:0] PH_LITERAL  = 3'd6;
    localparam logic [2:0] PH_DRAIN    = 3'd7;

    // Command kinds
    localparam logic [1:0] KIND_LONG_RUN  = 2'd0;
    localparam logic [1:0] KIND_SHORT_RUN = 2'd1;
    localparam logic [1:0] KIND_LONG_LIT  = 2'd2;
    localparam logic [1:0] KIND_HELD_LIT  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CLIP = 2'd1;
    localparam logic [1:0] ST_PAD  = 2'd2;

    // Count biases
    localparam logic [14:0] LONG_RUN_BIAS  = 15'h44;
    localparam logic [14:0] LONG_LIT_BIAS  = 15'h41;
    localparam logic [14:0] SHORT_RUN_BIAS = 15'd4;

    // Result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] repeat_res;
        logic        frame_end;
        logic [1:0]  status;
    } res_t;

    typedef struct packed {
        res_t        res;
        logic [15:0] rem;
        logic        full;
    } emit_t;

endpackage

`default_nettype wire

// ===== design/rle_byte_stream_decoder_top.sv =====
// Run-length byte stream decoder: header and command parser with a result queue.
//
// Usage:
//   s_* channel takes one compressed byte per word: tdata = byte, tlast marks
//   the final byte of the frame. The first two bytes are the declared output
//   length, low byte first, followed by control bytes and their operands.
//   m_* channel gives one result per word: tdata = {repeat_res, out_byte},
//   tlast = frame_end, tuser = status (ok, clipped, zero padding).
//   A byte is parsed in the cycle it is accepted; its results are written
//   to a 4-entry result queue and appear on m_* in order from its head.
//   Throughput is one byte per cycle while at most one result waits in the
//   queue; s_tready is low while two or more results wait. m_* moves one
//   word per cycle, so a byte that yields two or three results (held-byte
//   literal end, early end) holds s_tready low until at most one result waits,
//   even with the receiver always ready.
//   Reset empties the queue and puts the parser at the length low byte.
//   When the receiver stalls, the queue fills and s_tready falls; nothing
//   is lost or reordered.
`default_nettype none

module rle_byte_stream_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] repeat_res
    output logic             m_tlast,
    output logic [1:0]       m_tuser    // [1:0] status
);
    import rbsd_pkg::*;

`include "rle_byte_stream_decoder_top_defines.svh"

    // Parser state
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [14:0] pc_reg, pc_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  held_reg, held_next;

    // Result queue
    res_t              rq_mem [RQ_DEPTH];
    logic [RQ_AW-1:0]  wr_ptr_reg;
    logic [RQ_AW-1:0]  rd_ptr_reg;
    logic [RQ_AW:0]    cnt_reg;

    res_t        res [3];
    logic [1:0]  n_res;
    logic        accept;
    logic        pop;

    function automatic res_t mk_res(input logic [7:0] b, input logic [15:0] rep,
                                    input logic fe, input logic [1:0] st);
        res_t r;
        r.out_byte   = b;
        r.repeat_res = rep;
        r.frame_end  = fe;
        r.status     = st;
        return r;
    endfunction

    // Clip a run to what is still owed; flag clipping and frame full
    function automatic emit_t emit_f(input logic [15:0] rem, input logic [7:0] b,
                                     input logic [15:0] cnt, input logic more);
        logic [15:0] c;
        logic [1:0]  st;
        emit_t       e;
        c  = cnt;
        st = ST_OK;
        if (cnt > rem)
        begin
            c  = rem;
            st = ST_CLIP;
        end
        else if (cnt == rem && more)
        begin
            st = ST_CLIP;
        end
        e.rem  = rem - c;
        e.full = (e.rem == 16'd0);
        e.res  = mk_res(b, c, e.full, st);
        return e;
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= (RQ_AW+1)'(1));

    // Parse one byte
    always_comb
    begin
        logic  done;
        logic  last;
        logic  more;
        logic  [7:0] b;
        logic  [14:0] pcd;
        emit_t e;
        emit_t e2;

        b           = s_tdata;
        last        = s_tlast;
        done        = 1'b0;
        more        = 1'b0;
        pcd         = pc_reg - 15'd1;
        e           = '0;
        e2          = '0;
        phase_next  = phase_reg;
        rem_next    = rem_reg;
        len_lo_next = len_lo_reg;
        pc_next     = pc_reg;
        kind_next   = kind_reg;
        held_next   = held_reg;
        n_res       = 2'd0;
        res[0]      = '0;
        res[1]      = '0;
        res[2]      = '0;

        case (phase_reg)
            PH_LEN_LO:
            begin
                len_lo_next = b;
                if (last)
                begin
                    res[0]   = mk_res(8'd0, {8'd0, b}, 1'b1, (b == 8'd0) ? ST_OK : ST_PAD);
                    n_res    = 2'd1;
                    rem_next = 16'd0;
                    done     = 1'b1;
                end
                else
                begin
                    phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                rem_next = {b, len_lo_reg};
                if ({b, len_lo_reg} == 16'd0)
                begin
                    res[0] = mk_res(8'd0, 16'd0, 1'b1, ST_OK);
                    n_res  = 2'd1;
                    done   = 1'b1;
                end
                else
                begin
                    phase_next = PH_CTRL;
                end
            end
            PH_CTRL:
            begin
                if (b[7] && b[6])
                begin
                    kind_next  = KIND_LONG_RUN;
                    pc_next    = 15'(b[5:0]);
                    phase_next = PH_COUNT_LO;
                end
                else if (b[7])
                begin
                    kind_next  = KIND_SHORT_RUN;
                    pc_next    = 15'(b[5:0]) + SHORT_RUN_BIAS;
                    phase_next = PH_RUN_DATA;
                end
                else if (b[6])
                begin
                    kind_next  = KIND_LONG_LIT;
                    pc_next    = 15'(b[5:0]);
                    phase_next = PH_COUNT_LO;
                end
                else
                begin
                    kind_next  = KIND_HELD_LIT;
                    pc_next    = 15'(b[5:0]);
                    phase_next = PH_HELD;
                end
            end
            PH_COUNT_LO:
            begin
                if (kind_reg == KIND_LONG_RUN)
                begin
                    pc_next    = {1'b0, pc_reg[5:0], b} + LONG_RUN_BIAS;
                    phase_next = PH_RUN_DATA;
                end
                else
                begin
                    pc_next    = {1'b0, pc_reg[5:0], b} + LONG_LIT_BIAS;
                    phase_next = PH_LITERAL;
                end
            end
            PH_RUN_DATA:
            begin
                e          = emit_f(rem_reg, b, {1'b0, pc_reg}, 1'b0);
                res[0]     = e.res;
                n_res      = 2'd1;
                rem_next   = e.rem;
                done       = e.full;
                pc_next    = 15'd0;
                phase_next = PH_CTRL;
            end
            PH_HELD:
            begin
                held_next = b;
                if (pc_reg == 15'd0)
                begin
                    e          = emit_f(rem_reg, b, 16'd1, 1'b0);
                    res[0]     = e.res;
                    n_res      = 2'd1;
                    rem_next   = e.rem;
                    done       = e.full;
                    phase_next = PH_CTRL;
                end
                else
                begin
                    phase_next = PH_LITERAL;
                end
            end
            PH_LITERAL:
            begin
                pc_next  = pcd;
                more     = (pcd != 15'd0) || (kind_reg == KIND_HELD_LIT);
                e        = emit_f(rem_reg, b, 16'd1, more);
                res[0]   = e.res;
                n_res    = 2'd1;
                rem_next = e.rem;
                done     = e.full;
                if (!e.full && pcd == 15'd0)
                begin
                    // Held byte closes the literal
                    if (kind_reg == KIND_HELD_LIT)
                    begin
                        e2       = emit_f(e.rem, held_reg, 16'd1, 1'b0);
                        res[1]   = e2.res;
                        n_res    = 2'd2;
                        rem_next = e2.rem;
                        done     = e2.full;
                    end
                    phase_next = PH_CTRL;
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase

        // Frame end handling: drain after full unless the byte was last, zero padding on early end
        if (done)
        begin
            pc_next    = 15'd0;
            phase_next = last ? PH_LEN_LO : PH_DRAIN;
        end
        else if (last)
        begin
            res[n_res] = mk_res(8'd0, rem_next, 1'b1, ST_PAD);
            n_res      = n_res + 2'd1;
            rem_next   = 16'd0;
            pc_next    = 15'd0;
            phase_next = PH_LEN_LO;
        end
    end

    // Parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN_LO;
            rem_reg    <= 16'd0;
            len_lo_reg <= 8'd0;
            pc_reg     <= 15'd0;
            kind_reg   <= KIND_LONG_RUN;
            held_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            rem_reg    <= rem_next;
            len_lo_reg <= len_lo_next;
            pc_reg     <= pc_next;
            kind_reg   <= kind_next;
            held_reg   <= held_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < n_res)
                begin
                    rq_mem[wr_ptr_reg + RQ_AW'(i)] <= res[i];
                end
            end
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + RQ_AW'(n_res);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + RQ_AW'(1);
            end
            cnt_reg <= cnt_reg + (accept ? (RQ_AW+1)'(n_res) : '0) - (pop ? (RQ_AW+1)'(1) : '0);
        end
    end

    // Output word from queue head
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {rq_mem[rd_ptr_reg].repeat_res, rq_mem[rd_ptr_reg].out_byte};
    assign m_tlast  = rq_mem[rd_ptr_reg].frame_end;
    assign m_tuser  = rq_mem[rd_ptr_reg].status;

    // Checks
    `RBSD_ASSERT(a_rq_no_overflow, cnt_reg <= (RQ_AW+1)'(RQ_DEPTH), "result queue overflow")
    `RBSD_ASSERT(a_last_restarts, accept && s_tlast |=> phase_reg == PH_LEN_LO, "no restart")
    `RBSD_ASSERT(a_pad_ends_frame, m_tvalid && m_tuser == ST_PAD |-> m_tlast, "padding word without frame end")
    `RBSD_ASSERT(a_empty_marker, m_tvalid && m_tdata[23:8] == 16'd0 |-> m_tlast, "zero repeat word not at frame end")

endmodule

`default_nettype wire
